>>> rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types, constants and helpers of the thick line clearance check.
// ----------------------------------------------------------------------------
package tcc_pkg;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int COORD_BITS     = 12;
	localparam int FRAC_BITS      = 16;
	localparam int PT_W           = 16;
	localparam int CFG_W          = 12;
	localparam int CFG_IDX_W      = 1;
	localparam int SW             = 34;
	localparam int LW             = 30;
	localparam int DNW            = 48;
	localparam int PW             = 24;
	localparam int VW             = 24;
	localparam int GW             = 20;
	localparam int EW             = 20;

	localparam logic [CFG_IDX_W-1:0] REG_AGENT_RADIUS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT  = 1'd1;
	localparam logic [CFG_W-1:0]     AGENT_RADIUS_RST = 12'd128;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_WRITE,
		OP_LOAD,
		OP_SQ,
		OP_SQRT,
		OP_MUL,
		OP_GAP,
		OP_DIV,
		OP_EXTRA,
		OP_NSTEP,
		OP_BAND_LO,
		OP_BAND_HI,
		OP_BAND_END,
		OP_KINIT,
		OP_KSTEP,
		OP_SCAN_START,
		OP_SCAN,
		OP_MAIN_INIT,
		OP_MAIN_ADV
	} dp_op_t;

	typedef enum logic [2:0] {
		SEL_A,
		SEL_B,
		SEL_UP,
		SEL_DN,
		SEL_CELL
	} probe_sel_t;

	typedef struct packed {
		dp_op_t     op;
		probe_sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		logic sqrt_last;
		logic div_last;
		logic len_zero;
		logic scan_done;
		logic scan_hit;
		logic n_end;
		logic k_end;
		logic up_cond;
		logic dn_cond;
		logic main_end;
	} dp_stat_t;

	// Rounds a Q.16 value up to an integer and takes one off, never below zero.
	function automatic logic [47:0] q16_to_int(input logic [63:0] v);
		logic [63:0] c;
		c = (v + 64'hFFFF) >> FRAC_BITS;
		return (c == 64'd0) ? 48'd0 : (c[47:0] - 48'd1);
	endfunction

endpackage

>>> rtl/tcc_datapath.sv
// ----------------------------------------------------------------------------
// tcc_datapath
// Point table, configuration registers, square root, divider, line walk
// registers and the table scan that tests one probed cell.
// ----------------------------------------------------------------------------
module tcc_datapath #(
	parameter int MAX_POINTS = tcc_pkg::MAX_POINTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tcc_pkg::dp_cmd_t                cmd,
	output tcc_pkg::dp_stat_t               stat,
	input  logic                            cfg_we,
	input  logic [tcc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tcc_pkg::CFG_W-1:0]       cfg_data,
	input  logic [9:0]                      point_index,
	input  logic [15:0]                     point_x,
	input  logic [15:0]                     point_y,
	input  logic [11:0]                     start_x,
	input  logic [11:0]                     start_y,
	input  logic [11:0]                     end_x,
	input  logic [11:0]                     end_y
);
	import tcc_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam logic signed [PW-1:0] GRID_LIM = PW'(1 << COORD_BITS);

	logic [CFG_W-1:0] radius_q;
	logic [10:0]      count_q;
	logic [CW-1:0]    n_eff;

	logic [31:0]      table_q [MAX_POINTS];
	logic [31:0]      rd_s1;
	logic             rv_s1;
	logic [CW-1:0]    i_q;
	logic             hit_q;
	logic [PT_W-1:0]  tgt_x_q;
	logic [PT_W-1:0]  tgt_y_q;

	logic             ymaj_q;
	logic             sminpos_q;
	logic [11:0]      dx_q;
	logic [11:0]      dy_q;
	logic [11:0]      dmaj_q;
	logic [11:0]      dmin_q;
	logic signed [PW-1:0] maj1_q, mnr1_q, maj2_q, mnr2_q;
	logic signed [PW-1:0] maj_q, mnr_q, pa_maj_q, pb_maj_q, pmaj_q, pmnr_q;
	logic             pdir_q;
	logic signed [VW-1:0] err_q;
	logic [GW-1:0]    gap_q;
	logic [EW-1:0]    extra_q;
	logic [EW-1:0]    n_q;
	logic [VW-1:0]    num_q;
	logic [VW-1:0]    k_q;

	logic [SW-1:0]    sh_q;
	logic [SW-1:0]    rem_q;
	logic [LW-1:0]    root_q;
	logic [5:0]       scnt_q;
	logic [41:0]      prodg_q;
	logic [23:0]      prode_q;
	logic [DNW-1:0]   dnum_q;
	logic [LW-1:0]    dden_q;
	logic [LW-1:0]    drem_q;
	logic [5:0]       dcnt_q;

	logic [11:0]      dx_c, dy_c, ox1, oy1, ox2, oy2;
	logic             swap_c, ymaj_c;
	logic [SW-1:0]    rem_n, trial;
	logic [LW:0]      dtrial;
	logic             dge;
	logic signed [VW-1:0] dmin_s, dmaj_s, gap_s, e1, v_lo, v_hi;
	logic signed [PW-1:0] extra_s, cx_c, cy_c;
	logic             off_c;
	logic [63:0]      gv;

	always_comb begin
		if (32'(count_q) > 32'(MAX_POINTS)) begin
			n_eff = CW'(MAX_POINTS);
		end else begin
			n_eff = CW'(count_q);
		end
	end

	assign dx_c   = (start_x > end_x) ? (start_x - end_x) : (end_x - start_x);
	assign dy_c   = (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);
	assign swap_c = ((dx_c > dy_c) && (start_x > end_x)) || ((dy_c >= dx_c) && (start_y > end_y));
	assign ymaj_c = !(dx_c > dy_c);
	assign ox1    = swap_c ? end_x : start_x;
	assign oy1    = swap_c ? end_y : start_y;
	assign ox2    = swap_c ? start_x : end_x;
	assign oy2    = swap_c ? start_y : end_y;

	assign rem_n  = {rem_q[SW-3:0], sh_q[SW-1 -: 2]};
	assign trial  = SW'({root_q, 2'b01});
	assign dtrial = {drem_q, dnum_q[DNW-1]};
	assign dge    = dtrial >= {1'b0, dden_q};

	assign dmin_s  = VW'(dmin_q);
	assign dmaj_s  = VW'(dmaj_q);
	assign gap_s   = VW'(gap_q);
	assign e1      = err_q + dmin_s;
	assign v_lo    = gap_s - err_q;
	assign v_hi    = gap_s + err_q;
	assign extra_s = PW'(extra_q);
	assign cx_c    = ymaj_q ? pmnr_q : pmaj_q;
	assign cy_c    = ymaj_q ? pmaj_q : pmnr_q;
	assign off_c   = (cx_c < 0) || (cy_c < 0) || (cx_c >= GRID_LIM) || (cy_c >= GRID_LIM);
	assign gv      = 64'(prodg_q >> 8) + ((64'(dx_q) + 64'(dy_q)) << 15);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= AGENT_RADIUS_RST;
			count_q  <= '0;
			hit_q    <= 1'b0;
			rv_s1    <= 1'b0;
			i_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_AGENT_RADIUS: radius_q <= cfg_data;
					REG_POINT_COUNT:  count_q  <= cfg_data[10:0];
					default: ;
				endcase
			end
			rv_s1 <= (cmd.op == OP_SCAN) && (i_q < n_eff);
			if (cmd.op == OP_LOAD) begin
				hit_q <= 1'b0;
			end else if (rv_s1 && (rd_s1[15:0] == tgt_x_q) && (rd_s1[31:16] == tgt_y_q)) begin
				hit_q <= 1'b1;
			end
			if (cmd.op == OP_SCAN_START) begin
				i_q <= off_c ? n_eff : '0;
			end else if ((cmd.op == OP_SCAN) && (i_q < n_eff)) begin
				i_q <= i_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.op == OP_WRITE) && (32'(point_index) < 32'(MAX_POINTS))) begin
			table_q[AW'(point_index)] <= {point_y, point_x};
		end
		if ((cmd.op == OP_SCAN) && (i_q < n_eff)) begin
			rd_s1 <= table_q[i_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				ymaj_q    <= ymaj_c;
				dx_q      <= dx_c;
				dy_q      <= dy_c;
				dmaj_q    <= ymaj_c ? dy_c : dx_c;
				dmin_q    <= ymaj_c ? dx_c : dy_c;
				maj1_q    <= PW'(ymaj_c ? oy1 : ox1);
				mnr1_q    <= PW'(ymaj_c ? ox1 : oy1);
				maj2_q    <= PW'(ymaj_c ? oy2 : ox2);
				mnr2_q    <= PW'(ymaj_c ? ox2 : oy2);
				sminpos_q <= ymaj_c ? (ox1 < ox2) : (oy1 < oy2);
				gap_q     <= '0;
				extra_q   <= '0;
			end
			OP_SQ: begin
				sh_q   <= SW'(24'(dx_q) * 24'(dx_q)) + SW'(24'(dy_q) * 24'(dy_q));
				rem_q  <= '0;
				root_q <= '0;
				scnt_q <= '0;
			end
			OP_SQRT: begin
				if (rem_n >= trial) begin
					rem_q  <= rem_n - trial;
					root_q <= {root_q[LW-2:0], 1'b1};
				end else begin
					rem_q  <= rem_n;
					root_q <= {root_q[LW-2:0], 1'b0};
				end
				sh_q   <= {sh_q[SW-3:0], 2'b00};
				scnt_q <= scnt_q + 6'd1;
			end
			OP_MUL: begin
				prodg_q <= 42'(radius_q) * 42'(root_q);
				prode_q <= 24'(radius_q) * 24'(dmin_q);
			end
			OP_GAP: begin
				gap_q  <= GW'(q16_to_int(gv));
				dnum_q <= {prode_q, 24'd0};
				dden_q <= root_q;
				drem_q <= '0;
				dcnt_q <= '0;
			end
			OP_DIV: begin
				drem_q <= dge ? LW'(dtrial - {1'b0, dden_q}) : dtrial[LW-1:0];
				dnum_q <= {dnum_q[DNW-2:0], dge};
				dcnt_q <= dcnt_q + 6'd1;
			end
			OP_EXTRA: begin
				extra_q  <= EW'(q16_to_int(64'(dnum_q) + 64'd32768));
				n_q      <= '0;
				err_q    <= '0;
				pa_maj_q <= maj1_q;
				pb_maj_q <= maj2_q;
			end
			OP_NSTEP: begin
				n_q      <= n_q + EW'(1);
				err_q    <= e1;
				pa_maj_q <= pa_maj_q - PW'(1);
				pb_maj_q <= pb_maj_q + PW'(1);
			end
			OP_BAND_LO, OP_BAND_HI: begin
				if (cmd.op == OP_BAND_LO) begin
					dnum_q <= (v_lo > 0) ? DNW'($unsigned(v_lo)) : '0;
				end else begin
					dnum_q <= (v_hi > 0) ? DNW'($unsigned(v_hi)) : '0;
				end
				dden_q <= LW'(dmaj_q);
				drem_q <= '0;
				dcnt_q <= '0;
			end
			OP_BAND_END: begin
				num_q <= dnum_q[VW-1:0];
			end
			OP_KINIT: begin
				k_q <= '0;
				case (cmd.sel)
					SEL_A: begin
						pmaj_q <= pa_maj_q;
						pmnr_q <= mnr1_q;
						pdir_q <= sminpos_q;
					end
					SEL_B: begin
						pmaj_q <= pb_maj_q;
						pmnr_q <= mnr2_q;
						pdir_q <= !sminpos_q;
					end
					SEL_UP: begin
						pmaj_q <= maj_q;
						pmnr_q <= mnr_q;
						pdir_q <= sminpos_q;
					end
					SEL_DN: begin
						pmaj_q <= maj_q;
						pmnr_q <= mnr_q;
						pdir_q <= !sminpos_q;
					end
					default: begin
						pmaj_q <= maj_q;
						pmnr_q <= mnr_q;
						pdir_q <= sminpos_q;
					end
				endcase
			end
			OP_KSTEP: begin
				k_q    <= k_q + VW'(1);
				pmnr_q <= pdir_q ? (pmnr_q + PW'(1)) : (pmnr_q - PW'(1));
			end
			OP_SCAN_START: begin
				tgt_x_q <= {cx_c[COORD_BITS-1:0], 4'b0000};
				tgt_y_q <= {cy_c[COORD_BITS-1:0], 4'b0000};
			end
			OP_MAIN_INIT: begin
				err_q <= '0;
				mnr_q <= mnr1_q;
				maj_q <= maj1_q;
			end
			OP_MAIN_ADV: begin
				if ((e1 <<< 1) > dmaj_s) begin
					mnr_q <= sminpos_q ? (mnr_q + PW'(1)) : (mnr_q - PW'(1));
					err_q <= e1 - dmaj_s;
				end else begin
					err_q <= e1;
				end
				maj_q <= maj_q + PW'(1);
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.sqrt_last = scnt_q == 6'd32;
		stat.div_last  = dcnt_q == 6'(DNW - 1);
		stat.len_zero  = root_q == '0;
		stat.scan_done = (i_q >= n_eff) && !rv_s1;
		stat.scan_hit  = hit_q;
		stat.n_end     = n_q == extra_q;
		stat.k_end     = k_q == num_q;
		stat.up_cond   = maj_q < (maj2_q - extra_s);
		stat.dn_cond   = maj_q > (maj1_q + extra_s);
		stat.main_end  = maj_q > maj2_q;
	end

endmodule

>>> rtl/tcc_ctrl.sv
// ----------------------------------------------------------------------------
// tcc_ctrl
// Sequencer of the clearance check: steps the datapath through setup, the
// end extension loop and the main line walk, and holds the result register.
// ----------------------------------------------------------------------------
module tcc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              func,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              is_query,
	output logic              line_clear,
	output tcc_pkg::dp_cmd_t  cmd,
	input  tcc_pkg::dp_stat_t stat
);
	import tcc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ,
		ST_SQRT,
		ST_MUL,
		ST_GAP,
		ST_DIV,
		ST_EXTRA,
		ST_X_TEST,
		ST_X_BAND,
		ST_BAND_END,
		ST_K_INIT,
		ST_K_TEST,
		ST_SCAN_START,
		ST_SCAN,
		ST_XB_START,
		ST_M_INIT,
		ST_M_CELL,
		ST_M_UP,
		ST_M_DN,
		ST_M_ADV,
		ST_M_TEST,
		ST_RESP
	} state_t;

	state_t     state_q, dret_q, kret_q, sret_q;
	probe_sel_t sel_q;
	logic       out_valid_q, is_query_q, line_clear_q;

	assign in_ready   = state_q == ST_IDLE;
	assign out_valid  = out_valid_q;
	assign is_query   = is_query_q;
	assign line_clear = line_clear_q;

	always_comb begin
		cmd.op  = OP_NONE;
		cmd.sel = sel_q;
		case (state_q)
			ST_IDLE:       if (in_valid) cmd.op = func ? OP_LOAD : OP_WRITE;
			ST_SQ:         cmd.op = OP_SQ;
			ST_SQRT:       cmd.op = OP_SQRT;
			ST_MUL:        if (!stat.len_zero) cmd.op = OP_MUL;
			ST_GAP:        cmd.op = OP_GAP;
			ST_DIV:        cmd.op = OP_DIV;
			ST_EXTRA:      cmd.op = OP_EXTRA;
			ST_X_TEST:     if (!stat.n_end) cmd.op = OP_NSTEP;
			ST_X_BAND:     cmd.op = OP_BAND_LO;
			ST_BAND_END:   cmd.op = OP_BAND_END;
			ST_K_INIT:     cmd.op = OP_KINIT;
			ST_K_TEST:     if (!stat.k_end) cmd.op = OP_KSTEP;
			ST_SCAN_START: cmd.op = OP_SCAN_START;
			ST_SCAN:       cmd.op = OP_SCAN;
			ST_XB_START: begin
				cmd.op  = OP_KINIT;
				cmd.sel = SEL_B;
			end
			ST_M_INIT:     cmd.op = OP_MAIN_INIT;
			ST_M_CELL: begin
				cmd.op  = OP_KINIT;
				cmd.sel = SEL_CELL;
			end
			ST_M_UP:       if (stat.up_cond) cmd.op = OP_BAND_HI;
			ST_M_DN:       if (stat.dn_cond) cmd.op = OP_BAND_LO;
			ST_M_ADV:      cmd.op = OP_MAIN_ADV;
			default:       cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			dret_q       <= ST_IDLE;
			kret_q       <= ST_IDLE;
			sret_q       <= ST_IDLE;
			sel_q        <= SEL_CELL;
			out_valid_q  <= 1'b0;
			is_query_q   <= 1'b0;
			line_clear_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (func) begin
							state_q <= ST_SQ;
						end else begin
							out_valid_q  <= 1'b1;
							is_query_q   <= 1'b0;
							line_clear_q <= 1'b0;
							state_q      <= ST_RESP;
						end
					end
				end
				ST_SQ: state_q <= ST_SQRT;
				ST_SQRT: if (stat.sqrt_last) state_q <= ST_MUL;
				ST_MUL: state_q <= stat.len_zero ? ST_M_INIT : ST_GAP;
				ST_GAP: begin
					dret_q  <= ST_EXTRA;
					state_q <= ST_DIV;
				end
				ST_DIV: if (stat.div_last) state_q <= dret_q;
				ST_EXTRA: state_q <= ST_X_TEST;
				ST_X_TEST: state_q <= stat.n_end ? ST_M_INIT : ST_X_BAND;
				ST_X_BAND: begin
					dret_q  <= ST_BAND_END;
					sel_q   <= SEL_A;
					kret_q  <= ST_XB_START;
					state_q <= ST_DIV;
				end
				ST_BAND_END: state_q <= ST_K_INIT;
				ST_K_INIT: state_q <= ST_K_TEST;
				ST_K_TEST: begin
					if (stat.k_end) begin
						state_q <= kret_q;
					end else begin
						sret_q  <= ST_K_TEST;
						state_q <= ST_SCAN_START;
					end
				end
				ST_SCAN_START: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (stat.scan_hit) begin
						out_valid_q  <= 1'b1;
						is_query_q   <= 1'b1;
						line_clear_q <= 1'b0;
						state_q      <= ST_RESP;
					end else if (stat.scan_done) begin
						state_q <= sret_q;
					end
				end
				ST_XB_START: begin
					kret_q  <= ST_X_TEST;
					state_q <= ST_K_TEST;
				end
				ST_M_INIT: state_q <= ST_M_CELL;
				ST_M_CELL: begin
					sret_q  <= ST_M_UP;
					state_q <= ST_SCAN_START;
				end
				ST_M_UP: begin
					if (stat.up_cond) begin
						dret_q  <= ST_BAND_END;
						sel_q   <= SEL_UP;
						kret_q  <= ST_M_DN;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_M_DN;
					end
				end
				ST_M_DN: begin
					if (stat.dn_cond) begin
						dret_q  <= ST_BAND_END;
						sel_q   <= SEL_DN;
						kret_q  <= ST_M_ADV;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_M_ADV;
					end
				end
				ST_M_ADV: state_q <= ST_M_TEST;
				ST_M_TEST: begin
					if (stat.main_end) begin
						out_valid_q  <= 1'b1;
						is_query_q   <= 1'b1;
						line_clear_q <= 1'b1;
						state_q      <= ST_RESP;
					end else begin
						state_q <= ST_M_CELL;
					end
				end
				ST_RESP: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/thick_line_clearance_check.sv
// ----------------------------------------------------------------------------
// thick_line_clearance_check
// A write transaction is acknowledged in the cycle after acceptance, and the
// next transaction is taken in the cycle after the result leaves. A query runs
// the square root steps, then the divider steps when the line has length, then
// scans the point table for each probed cell, walks the line cell by cell and
// sizes each band with the divider; the first hit ends the query at once.
// Reset is asynchronous, active low: agent_radius 128, point_count 0, table kept.
// ----------------------------------------------------------------------------
module thick_line_clearance_check #(
	parameter int MAX_POINTS = tcc_pkg::MAX_POINTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [9:0]                    point_index,
	input  logic [15:0]                   point_x,
	input  logic [15:0]                   point_y,
	input  logic [11:0]                   start_x,
	input  logic [11:0]                   start_y,
	input  logic [11:0]                   end_x,
	input  logic [11:0]                   end_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          is_query,
	output logic                          line_clear,
	input  logic                          cfg_we,
	input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcc_pkg::CFG_W-1:0]     cfg_data
);
	import tcc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	tcc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.is_query   (is_query),
		.line_clear (line_clear),
		.cmd        (cmd),
		.stat       (stat)
	);

	tcc_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.point_index (point_index),
		.point_x     (point_x),
		.point_y     (point_y),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y)
	);

endmodule

>>> rtl/tcc_checker.sv
// ----------------------------------------------------------------------------
// tcc_checker
// Port level checks of the clearance check, bound to the top level.
// ----------------------------------------------------------------------------
module tcc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          func,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          is_query,
	input logic                          line_clear
);

	// A write acknowledge never reports a clear line.
	a_ack_not_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_query |-> !line_clear)
		else $error("write acknowledge reports a clear line");

	// Only one transaction is in flight, so no input is taken while a result waits.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is pending");

	// An accepted write is acknowledged in the next cycle.
	a_write_ack: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !func |=> out_valid && !is_query)
		else $error("write transaction not acknowledged");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(is_query) && $stable(line_clear))
		else $error("stalled result changed");

endmodule

bind thick_line_clearance_check tcc_checker u_tcc_checker (.*);
